[rtl/core/rfcd_pkg.sv]
`timescale 1ns / 1ps

package rfcd_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [4:0]  pos_t;
  typedef logic [4:0]  cmd_t;
  typedef logic [2:0]  sel_t;
  typedef logic [15:0] len_t;

  // Byte positions inside the frame
  localparam pos_t PosType   = 5'd3;
  localparam pos_t PosClass  = 5'd15;
  localparam pos_t PosLetter = 5'd16;
  localparam pos_t PosArgHi  = 5'd17;
  localparam pos_t PosArgLo  = 5'd18;
  localparam pos_t PosSat    = 5'd19;

  localparam byte_t TypeRxPacket = 8'h90;

  // ASCII letters
  localparam byte_t ChA = 8'h41;
  localparam byte_t ChB = 8'h42;
  localparam byte_t ChC = 8'h43;
  localparam byte_t ChD = 8'h44;
  localparam byte_t ChF = 8'h46;
  localparam byte_t ChI = 8'h49;
  localparam byte_t ChL = 8'h4C;
  localparam byte_t ChM = 8'h4D;
  localparam byte_t ChP = 8'h50;
  localparam byte_t ChQ = 8'h51;
  localparam byte_t ChR = 8'h52;
  localparam byte_t ChS = 8'h53;
  localparam byte_t ChT = 8'h54;
  localparam byte_t ChU = 8'h55;
  localparam byte_t ChV = 8'h56;
  localparam byte_t ChW = 8'h57;
  localparam byte_t ChZ = 8'h5A;

  // Command codes
  localparam cmd_t CmdNone         = 5'd0;
  localparam cmd_t CmdChgSink      = 5'd1;
  localparam cmd_t CmdDbgBcast     = 5'd2;
  localparam cmd_t CmdChgChannel   = 5'd3;
  localparam cmd_t CmdChgPower     = 5'd4;
  localparam cmd_t CmdChgPeriod    = 5'd5;
  localparam cmd_t CmdDbgUcast     = 5'd6;
  localparam cmd_t CmdChgId        = 5'd7;
  localparam cmd_t CmdChgLocation  = 5'd8;
  localparam cmd_t CmdCommit       = 5'd9;
  localparam cmd_t CmdChgFlag      = 5'd10;
  localparam cmd_t CmdChgRetries   = 5'd11;
  localparam cmd_t CmdQrySink      = 5'd12;
  localparam cmd_t CmdQryPower     = 5'd13;
  localparam cmd_t CmdQryStatus    = 5'd14;
  localparam cmd_t CmdQryPeriod    = 5'd15;
  localparam cmd_t CmdQryFlag      = 5'd16;
  localparam cmd_t CmdQryVersion   = 5'd17;
  localparam cmd_t CmdQryRetries   = 5'd18;
  localparam cmd_t CmdStart        = 5'd19;
  localparam cmd_t CmdTimedSleep   = 5'd20;
  localparam cmd_t CmdMax          = 5'd20;

  // Radio parameter selectors
  localparam sel_t SelNone    = 3'd0;
  localparam sel_t SelChannel = 3'd1;
  localparam sel_t SelPower   = 3'd2;
  localparam sel_t SelWrite   = 3'd3;
  localparam sel_t SelRetries = 3'd4;

  // Frame lengths checked by the decoder
  localparam len_t Len13 = 16'd13;
  localparam len_t Len14 = 16'd14;
  localparam len_t Len15 = 16'd15;
  localparam len_t Len16 = 16'd16;
  localparam len_t Len22 = 16'd22;

endpackage

[rtl/core/rx_frame_command_decoder.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  frame_byte, byte_last, frame_length
// out_     output     out_valid/out_stall command_code, argument_value, argument_set,
//                                         radio_param_sel, radio_param_set
//
// One byte is taken per cycle while in_stall is low. A byte marked last enters a capture
// stage holding the frame fields, and its result then moves into the output register, so
// the path has two register stages. Bytes that are not last give no
// result. Reset (synchronous, rst_n low) clears the byte counter, the frame fields and
// both valid flags. A stall on out_ backs up into in_stall only when the capture stage
// holds a last byte that cannot move on.

module rx_frame_command_decoder
  import rfcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_byte_last,
  input  logic [15:0] in_frame_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_command_code,
  output logic [15:0] out_argument_value,
  output logic        out_argument_set,
  output logic [2:0]  out_radio_param_sel,
  output logic        out_radio_param_set
);

  // Frame state
  pos_t  pos_r;
  byte_t type_r, class_r, letter_r, arg_hi_r, arg_lo_r;

  // Capture stage
  logic  s1_valid_r;
  byte_t s1_type_r, s1_class_r, s1_letter_r, s1_hi_r, s1_lo_r;
  len_t  s1_len_r;

  // Output register
  logic        out_valid_r;
  cmd_t        out_cmd_r;
  logic [15:0] out_arg_r;
  logic        out_aset_r;
  sel_t        out_sel_r;
  logic        out_sset_r;

  logic  out_ready, s1_ready, in_acc;
  byte_t type_nxt, class_nxt, letter_nxt, arg_hi_nxt, arg_lo_nxt;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || out_ready;
  assign in_stall  = !s1_ready;
  assign in_acc    = in_valid && s1_ready;

  // Fields including the byte arriving now
  always_comb begin
    type_nxt   = (pos_r == PosType)   ? in_frame_byte : type_r;
    class_nxt  = (pos_r == PosClass)  ? in_frame_byte : class_r;
    letter_nxt = (pos_r == PosLetter) ? in_frame_byte : letter_r;
    arg_hi_nxt = (pos_r == PosArgHi)  ? in_frame_byte : arg_hi_r;
    arg_lo_nxt = (pos_r == PosArgLo)  ? in_frame_byte : arg_lo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      type_r   <= '0;
      class_r  <= '0;
      letter_r <= '0;
      arg_hi_r <= '0;
      arg_lo_r <= '0;
    end else if (in_acc) begin
      if (in_byte_last) begin
        // clear for the next frame
        pos_r    <= '0;
        type_r   <= '0;
        class_r  <= '0;
        letter_r <= '0;
        arg_hi_r <= '0;
        arg_lo_r <= '0;
      end else begin
        if (pos_r < PosSat) pos_r <= pos_r + 5'd1;
        type_r   <= type_nxt;
        class_r  <= class_nxt;
        letter_r <= letter_nxt;
        arg_hi_r <= arg_hi_nxt;
        arg_lo_r <= arg_lo_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_acc && in_byte_last;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_byte_last) begin
      s1_type_r   <= type_nxt;
      s1_class_r  <= class_nxt;
      s1_letter_r <= letter_nxt;
      s1_hi_r     <= arg_hi_nxt;
      s1_lo_r     <= arg_lo_nxt;
      s1_len_r    <= in_frame_length;
    end
  end

  // Command decode
  cmd_t        cmd;
  logic [15:0] arg;
  logic        aset;
  sel_t        sel;
  logic        sset;

  always_comb begin
    cmd  = CmdNone;
    arg  = '0;
    aset = 1'b0;
    sel  = SelNone;
    sset = 1'b0;
    unique case (s1_class_r)
      ChD: begin
        unique case (s1_letter_r)
          ChA: if (s1_len_r == Len22) cmd = CmdChgSink;
          ChB: if (s1_len_r == Len15) begin
            cmd = CmdDbgBcast; arg = {8'h00, s1_hi_r}; aset = 1'b1;
          end
          ChC: if (s1_len_r == Len15) begin
            cmd = CmdChgChannel; arg = {8'h00, s1_hi_r}; aset = 1'b1;
            sel = SelChannel; sset = 1'b1;
          end
          ChP: begin
            if (s1_len_r == Len15) begin
              cmd = CmdChgPower; arg = {8'h00, s1_hi_r}; aset = 1'b1;
              sel = SelPower; sset = 1'b1;
            end else if (s1_len_r == Len16 && s1_hi_r == ChL) begin
              cmd = CmdChgPower; arg = {8'h00, s1_lo_r}; aset = 1'b1;
              sel = SelPower; sset = 1'b1;
            end
          end
          ChT: begin
            if (s1_len_r == Len15) begin
              cmd = CmdChgPeriod; arg = {8'h00, s1_hi_r}; aset = 1'b1;
            end else if (s1_len_r == Len16) begin
              cmd = CmdChgPeriod; arg = {s1_hi_r, s1_lo_r}; aset = 1'b1;
            end
          end
          ChU: if (s1_len_r == Len15) begin
            cmd = CmdDbgUcast; arg = {8'h00, s1_hi_r}; aset = 1'b1;
          end
          ChI: cmd = CmdChgId;
          ChL: cmd = CmdChgLocation;
          ChW: if (s1_len_r == Len14) begin
            cmd = CmdCommit; sel = SelWrite; sset = 1'b1;
          end
          ChF: begin
            cmd = CmdChgFlag; arg = {8'h00, s1_hi_r}; aset = 1'b1;
          end
          ChM: if (s1_len_r == Len16 && s1_hi_r == ChR) begin
            cmd = CmdChgRetries; arg = {8'h00, s1_lo_r}; aset = 1'b1;
            sel = SelRetries; sset = 1'b1;
          end
          default: ;
        endcase
      end
      ChQ: begin
        unique case (s1_letter_r)
          ChA: if (s1_len_r == Len14) cmd = CmdQrySink;
          ChP: if (s1_len_r == Len14 || (s1_len_r == Len15 && s1_hi_r == ChL)) begin
            cmd = CmdQryPower; sel = SelPower; sset = 1'b1;
          end
          ChS: if (s1_len_r == Len14) cmd = CmdQryStatus;
          ChT: if (s1_len_r == Len14) cmd = CmdQryPeriod;
          ChF: if (s1_len_r == Len14) cmd = CmdQryFlag;
          ChV: if (s1_len_r == Len14) cmd = CmdQryVersion;
          ChM: if (s1_len_r == Len15 && s1_hi_r == ChR) begin
            cmd = CmdQryRetries; sel = SelRetries; sset = 1'b1;
          end
          default: ;
        endcase
      end
      ChS: begin
        if (s1_len_r == Len13) begin
          cmd = CmdStart;
        end else if (s1_len_r == Len14) begin
          cmd = CmdStart; arg = {8'h00, s1_letter_r}; aset = 1'b1;
        end else if (s1_len_r == Len15) begin
          cmd = CmdStart; arg = {s1_letter_r, s1_hi_r}; aset = 1'b1;
        end
      end
      ChZ: if (s1_len_r == Len15) begin
        cmd = CmdTimedSleep; arg = {s1_letter_r, s1_hi_r}; aset = 1'b1;
      end
      default: ;
    endcase
    // only received data packets carry a command; argument and selector still report
    if (s1_type_r != TypeRxPacket) cmd = CmdNone;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid_r) begin
      out_cmd_r  <= cmd;
      out_arg_r  <= arg;
      out_aset_r <= aset;
      out_sel_r  <= sel;
      out_sset_r <= sset;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_command_code    = out_cmd_r;
  assign out_argument_value  = out_arg_r;
  assign out_argument_set    = out_aset_r;
  assign out_radio_param_sel = out_sel_r;
  assign out_radio_param_set = out_sset_r;

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PosSat)
    else $error("byte counter past saturation");

  a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_byte_last |=> pos_r == '0)
    else $error("byte counter not cleared after last byte");

  a_arg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_aset_r |-> out_arg_r == '0)
    else $error("argument nonzero without argument flag");

  a_sel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_sset_r |-> out_sel_r == SelNone)
    else $error("selector nonzero without selector flag");

  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_cmd_r <= CmdMax)
    else $error("command code out of range");
`endif

endmodule
